// ----- src/wstfb_pkg.sv -----
`timescale 1ns / 1ps

package wstfb_pkg;

  // Input item function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  // Header constants of a text frame.
  localparam logic [7:0]  HDR_FIN_TEXT = 8'h81;
  localparam logic [62:0] SHORT_LIMIT  = 63'd125;
  localparam logic [62:0] MED_LIMIT    = 63'h0000_0000_0000_FFFF;
  localparam logic [6:0]  MED_CODE     = 7'd126;
  localparam logic [6:0]  LONG_CODE    = 7'd127;
  localparam logic [3:0]  EXT_NONE     = 4'd0;
  localparam logic [3:0]  EXT_MED      = 4'd2;
  localparam logic [3:0]  EXT_LONG     = 4'd8;
  localparam logic [3:0]  KEY_BYTES    = 4'd4;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic        func;
    logic [62:0] payload_len;
    logic        mask_enable;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic       is_header;
    logic       error;
  } out_item_t;

  typedef enum logic {
    CMD_HEADER,
    CMD_DATA
  } cmd_kind_t;

  // One queued command: a whole header burst, or one finished data byte or error result.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [62:0] len;
    logic [31:0] key;
    logic [7:0]  hdr_b1;
    logic [3:0]  ext_bytes;
    logic [3:0]  last_idx;
    logic [7:0]  data_byte;
    logic        last;
    logic        error;
  } cmd_t;

endpackage

// ----- src/wstfb_front.sv -----
`timescale 1ns / 1ps

module wstfb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wstfb_pkg::in_item_t in_data,
  output logic               push_valid,
  output wstfb_pkg::cmd_t    push_data,
  input  logic               queue_full
);

  logic [62:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]  key_phase_r, key_phase_nxt;
  logic [31:0] held_mask_r, held_mask_nxt;
  logic        masking_on_r, masking_on_nxt;
  logic        frame_open_r, frame_open_nxt;
  logic        accept;
  logic [7:0]  key_byte;

  assign in_stall   = queue_full;
  assign accept     = in_valid && !queue_full;
  assign push_valid = accept;

  always_comb begin
    case (key_phase_r)
      2'd0:    key_byte = held_mask_r[31:24];
      2'd1:    key_byte = held_mask_r[23:16];
      2'd2:    key_byte = held_mask_r[15:8];
      default: key_byte = held_mask_r[7:0];
    endcase
  end

  always_comb begin
    push_data      = '0;
    bytes_left_nxt = bytes_left_r;
    key_phase_nxt  = key_phase_r;
    held_mask_nxt  = held_mask_r;
    masking_on_nxt = masking_on_r;
    frame_open_nxt = frame_open_r;
    if (in_data.func == wstfb_pkg::FUNC_START) begin
      push_data.kind = wstfb_pkg::CMD_HEADER;
      push_data.len  = in_data.payload_len;
      push_data.key  = in_data.mask_key;
      if (in_data.payload_len <= wstfb_pkg::SHORT_LIMIT) begin
        push_data.hdr_b1    = {in_data.mask_enable, in_data.payload_len[6:0]};
        push_data.ext_bytes = wstfb_pkg::EXT_NONE;
      end else if (in_data.payload_len <= wstfb_pkg::MED_LIMIT) begin
        push_data.hdr_b1    = {in_data.mask_enable, wstfb_pkg::MED_CODE};
        push_data.ext_bytes = wstfb_pkg::EXT_MED;
      end else begin
        push_data.hdr_b1    = {in_data.mask_enable, wstfb_pkg::LONG_CODE};
        push_data.ext_bytes = wstfb_pkg::EXT_LONG;
      end
      push_data.last_idx = 4'd1 + push_data.ext_bytes +
                           (in_data.mask_enable ? wstfb_pkg::KEY_BYTES : 4'd0);
      // An empty frame ends on its own last header byte.
      push_data.last  = (in_data.payload_len == 63'd0);
      bytes_left_nxt  = in_data.payload_len;
      key_phase_nxt   = 2'd0;
      held_mask_nxt   = in_data.mask_key;
      masking_on_nxt  = in_data.mask_enable;
      frame_open_nxt  = (in_data.payload_len != 63'd0);
    end else begin
      push_data.kind = wstfb_pkg::CMD_DATA;
      if (!frame_open_r) begin
        push_data.error = 1'b1;
      end else begin
        push_data.data_byte = in_data.payload_byte ^ (masking_on_r ? key_byte : 8'd0);
        push_data.last      = (bytes_left_r == 63'd1);
        bytes_left_nxt      = bytes_left_r - 63'd1;
        key_phase_nxt       = key_phase_r + 2'd1;
        frame_open_nxt      = (bytes_left_r != 63'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      key_phase_r  <= '0;
      held_mask_r  <= '0;
      masking_on_r <= 1'b0;
      frame_open_r <= 1'b0;
    end else if (accept) begin
      bytes_left_r <= bytes_left_nxt;
      key_phase_r  <= key_phase_nxt;
      held_mask_r  <= held_mask_nxt;
      masking_on_r <= masking_on_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule

// ----- src/wstfb_queue.sv -----
`timescale 1ns / 1ps

module wstfb_queue #(
  parameter int DEPTH = wstfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  wstfb_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output wstfb_pkg::cmd_t head_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wstfb_pkg::cmd_t  entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/wstfb_back.sv -----
`timescale 1ns / 1ps

module wstfb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  wstfb_pkg::cmd_t      head_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wstfb_pkg::out_item_t out_data
);

  logic [3:0]           idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  wstfb_pkg::out_item_t out_data_r, out_data_nxt;
  logic                 advance;
  logic                 final_byte;
  logic [63:0]          len_wide;
  logic [2:0]           len_sel;
  logic [1:0]           key_sel;
  logic [7:0]           hdr_byte;

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign advance    = head_valid && (!out_valid_r || !out_stall);
  assign final_byte = (head_data.kind == wstfb_pkg::CMD_DATA) ||
                      (idx_r == head_data.last_idx);
  assign pop        = advance && final_byte;

  // Extended length goes out most significant byte first, then the key bytes.
  assign len_wide = {1'b0, head_data.len};
  assign len_sel  = 3'(head_data.ext_bytes + 4'd1 - idx_r);
  assign key_sel  = 2'(idx_r - 4'd2 - head_data.ext_bytes);

  always_comb begin
    if (idx_r == 4'd0) begin
      hdr_byte = wstfb_pkg::HDR_FIN_TEXT;
    end else if (idx_r == 4'd1) begin
      hdr_byte = head_data.hdr_b1;
    end else if (idx_r < 4'd2 + head_data.ext_bytes) begin
      hdr_byte = len_wide[{len_sel, 3'b000} +: 8];
    end else begin
      case (key_sel)
        2'd0:    hdr_byte = head_data.key[31:24];
        2'd1:    hdr_byte = head_data.key[23:16];
        2'd2:    hdr_byte = head_data.key[15:8];
        default: hdr_byte = head_data.key[7:0];
      endcase
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (advance) begin
      if (head_data.kind == wstfb_pkg::CMD_DATA) begin
        out_data_nxt.frame_byte = head_data.data_byte;
        out_data_nxt.is_header  = 1'b0;
      end else begin
        out_data_nxt.frame_byte = hdr_byte;
        out_data_nxt.is_header  = 1'b1;
      end
      out_data_nxt.last  = head_data.last && final_byte;
      out_data_nxt.error = head_data.error;
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      idx_nxt       = final_byte ? 4'd0 : idx_r + 4'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- src/websocket_text_frame_builder.sv -----
`timescale 1ns / 1ps
// An item is written into the command queue when it transfers; its first result then
//   enters the output register, from which it transfers out.
// Throughput: one payload byte per cycle while out_stall is low; a start item expands
//   into 2 to 14 header bytes, which the back end emits at one per cycle.
// The command queue (QUEUE_DEPTH entries) lets the front keep taking items meanwhile.
// Reset: synchronous, active low; closes any frame and empties queue and output.

module websocket_text_frame_builder #(
  parameter int QUEUE_DEPTH = wstfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wstfb_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wstfb_pkg::out_item_t out_data
);

  // The front tracks the open frame: it masks and counts payload bytes and
  // flags stray ones, and classifies each start into a header command with
  // its length code already chosen.
  logic            push_valid;
  wstfb_pkg::cmd_t push_data;
  logic            queue_full;

  // The queue decouples the two halves, so a header burst in the back end
  // does not hold off input transfers until the queue fills.
  logic            head_valid;
  wstfb_pkg::cmd_t head_data;
  logic            pop;

  wstfb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  wstfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // The back end walks a header command byte by byte, or passes a data
  // byte straight through, into the output register.
  wstfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int         CLK_HALF      = 6;
  localparam int         RESET_CYCLES  = 7;
  localparam int         RANDOM_ITEMS  = 300;
  localparam int         DRAIN_EVERY   = 80;
  // Cycles without any transfer on either channel before the run is declared hung.
  // The longest legal quiet stretch is a long sender gap or a long receiver stall,
  // so this leaves a wide margin.
  localparam int         IDLE_LIMIT    = 2000;
  // Extra cycles after the last expected byte, to catch stray results. A receiver
  // stall already under way is always shorter than this, so it runs out in time.
  localparam int         SETTLE_CYCLES = 64;
  localparam int         MAX_REPORTS   = 10;
  localparam logic [7:0] MASK_BIT      = 8'h80;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  wstfb_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  wstfb_pkg::out_item_t out_data;

  websocket_text_frame_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Our own copy of the encoder state. It starts out equal to the state after
  // reset, and reset is applied only once, so no separate clear is needed.
  logic [62:0] frame_bytes_left = '0;
  logic [1:0]  key_index        = '0;
  logic [31:0] frame_key        = '0;
  logic        frame_masked     = 1'b0;
  logic        frame_active     = 1'b0;

  // Encoded bytes that the block still owes us, oldest first.
  wstfb_pkg::out_item_t owed_bytes[$];

  int          fail_count  = 0;
  int          items_sent  = 0;
  int          idle_cycles = 0;

  // Phase switches for the random idling on each side. When a switch is off,
  // that side runs at full rate.
  bit          gaps_on     = 1'b1;
  bit          stalls_on   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void owe_byte(logic [7:0] b, logic lst, logic hdr, logic err);
    wstfb_pkg::out_item_t r;
    r.frame_byte = b;
    r.last       = lst;
    r.is_header  = hdr;
    r.error      = err;
    owed_bytes.push_back(r);
  endfunction

  // Works out the bytes that one accepted item must produce and advances the
  // encoder state.
  function automatic void encode_item(wstfb_pkg::in_item_t it);
    logic [7:0]  hdr[0:13];
    logic [63:0] len64;
    logic [7:0]  b1;
    logic [7:0]  b;
    int          ext;
    int          n;
    int          i;
    if (it.func == wstfb_pkg::FUNC_START) begin
      len64 = {1'b0, it.payload_len};
      b1    = it.mask_enable ? MASK_BIT : 8'h00;
      if (it.payload_len <= wstfb_pkg::SHORT_LIMIT) begin
        b1[6:0] = it.payload_len[6:0];
        ext     = int'(wstfb_pkg::EXT_NONE);
      end else if (it.payload_len <= wstfb_pkg::MED_LIMIT) begin
        b1[6:0] = wstfb_pkg::MED_CODE;
        ext     = int'(wstfb_pkg::EXT_MED);
      end else begin
        b1[6:0] = wstfb_pkg::LONG_CODE;
        ext     = int'(wstfb_pkg::EXT_LONG);
      end
      hdr[0] = wstfb_pkg::HDR_FIN_TEXT;
      hdr[1] = b1;
      n      = 2;
      // The extended length goes out most significant byte first.
      for (i = ext - 1; i >= 0; i--) begin
        hdr[n] = len64[8*i +: 8];
        n++;
      end
      if (it.mask_enable) begin
        for (i = 3; i >= 0; i--) begin
          hdr[n] = it.mask_key[8*i +: 8];
          n++;
        end
      end
      // An empty frame ends on its last header byte.
      for (i = 0; i < n; i++)
        owe_byte(hdr[i], (it.payload_len == '0) && (i == n - 1), 1'b1, 1'b0);
      // A start always replaces whatever frame was open.
      frame_bytes_left = it.payload_len;
      key_index        = '0;
      frame_key        = it.mask_key;
      frame_masked     = it.mask_enable;
      frame_active     = (it.payload_len != '0);
    end else if (!frame_active || frame_bytes_left == '0) begin
      // A payload byte with nowhere to go: error result, state untouched.
      owe_byte(8'h00, 1'b0, 1'b0, 1'b1);
    end else begin
      b = it.payload_byte;
      if (frame_masked)
        b ^= frame_key[8*(3 - key_index) +: 8];
      key_index++;
      frame_bytes_left--;
      if (frame_bytes_left == '0)
        frame_active = 1'b0;
      owe_byte(b, frame_bytes_left == '0, 1'b0, 1'b0);
    end
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t ns: %s", $time, msg);
  endfunction

  // One process per rising edge handles both channels. Each accepted input
  // transfer is encoded before the output channel is looked at, so the order
  // between prediction and checking never depends on the simulator. It also
  // runs the watchdog on cycles with no transfer at all.
  always @(posedge clk) begin : check_frames
    wstfb_pkg::out_item_t want;
    bit                   moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        encode_item(in_data);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (owed_bytes.size() == 0) begin
          note_failure($sformatf(
            "unexpected result: byte %02h last %b header %b error %b",
            out_data.frame_byte, out_data.last, out_data.is_header, out_data.error));
        end else begin
          want = owed_bytes.pop_front();
          if (out_data.frame_byte !== want.frame_byte || out_data.last !== want.last ||
              out_data.is_header !== want.is_header || out_data.error !== want.error)
            note_failure($sformatf({"result mismatch: expected byte %02h last %b ",
              "header %b error %b, got byte %02h last %b header %b error %b"},
              want.frame_byte, want.last, want.is_header, want.error,
              out_data.frame_byte, out_data.last, out_data.is_header, out_data.error));
        end
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // The receiver stalls in bursts: mostly short ones, now and then a long
  // one. A burst that has begun runs out even if stalling is switched off.
  initial begin : drive_out_stall
    int burst;
    burst     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (stalls_on && $urandom_range(0, 99) < 30) begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [62:0] random_len63();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[62:0];
  endfunction

  function automatic wstfb_pkg::in_item_t make_start(logic [62:0] len, logic msk,
                                                     logic [31:0] key);
    wstfb_pkg::in_item_t it;
    it.func         = wstfb_pkg::FUNC_START;
    it.payload_len  = len;
    it.mask_enable  = msk;
    it.mask_key     = key;
    it.payload_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Fields that a payload byte does not use carry random junk, which the
  // block must ignore.
  function automatic wstfb_pkg::in_item_t make_byte(logic [7:0] b);
    wstfb_pkg::in_item_t it;
    it.func         = wstfb_pkg::FUNC_DATA;
    it.payload_len  = random_len63();
    it.mask_enable  = 1'($urandom_range(0, 1));
    it.mask_key     = $urandom;
    it.payload_byte = b;
    return it;
  endfunction

  // Sends one item and returns right after the edge at which it transferred.
  // Valid is only ever changed at a falling edge, once per step.
  task automatic send_item(wstfb_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_payload(int count);
    repeat (count) send_item(make_byte(8'($urandom_range(0, 255))));
  endtask

  // The sender holds off until every owed byte has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk);
  endtask

  // A payload byte straight after reset finds no open frame.
  task automatic test_orphan_byte();
    send_item(make_byte(8'hA5));
  endtask

  // Zero-length frames are all header, with last on the final header byte,
  // and leave no frame open for the byte that follows.
  task automatic test_empty_frames();
    send_item(make_start('0, 1'b0, $urandom));
    send_item(make_start('0, 1'b1, 32'hFFFF_FFFF));
    send_item(make_byte(8'hFF));
  endtask

  // A masked short frame walks the key bytes once round and two more, then one byte too many.
  task automatic test_short_masked_frame();
    send_item(make_start(63'd6, 1'b1, 32'h1234_5678));
    send_item(make_byte(8'h00));
    send_item(make_byte(8'hFF));
    send_item(make_byte(8'h5A));
    send_item(make_byte(8'hA5));
    send_item(make_byte(8'h01));
    send_item(make_byte(8'h80));
    send_item(make_byte(8'h3C));
  endtask

  // Lengths on both sides of each length code, up to the largest one. Every
  // start abandons the frame the one before it opened.
  task automatic test_length_codes();
    send_item(make_start(wstfb_pkg::SHORT_LIMIT, 1'b0, $urandom));
    send_item(make_start(wstfb_pkg::SHORT_LIMIT + 63'd1, 1'b1, 32'hFFFF_FFFF));
    send_item(make_start(wstfb_pkg::MED_LIMIT, 1'b0, $urandom));
    send_item(make_start(wstfb_pkg::MED_LIMIT + 63'd1, 1'b1, 32'h0000_0000));
    send_item(make_start(63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 32'hDEAD_BEEF));
    send_item(make_byte(8'hFF));
    send_item(make_start(63'd1, 1'b0, $urandom));
    send_item(make_byte(8'h3C));
  endtask

  // A new start in the middle of a frame drops the old one and resets the
  // key position.
  task automatic test_abandoned_frame();
    send_item(make_start(63'd3, 1'b1, 32'hC3A5_0FF0));
    send_item(make_byte(8'h11));
    send_item(make_start(63'd2, 1'b0, $urandom));
    send_item(make_byte(8'h22));
    send_item(make_byte(8'h33));
  endtask

  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(0, 8);
    if (r < 96)
      return $urandom_range(9, 24);
    return $urandom_range(120, 132);
  endfunction

  // Mostly complete frames with random content and settings, some frames cut
  // short by the next start, and some noise: stray bytes and bare starts of
  // any length. Both sides' idling is switched on and off as it goes, and the
  // sender pauses for a full drain every so often.
  task automatic test_random_traffic();
    int          stop_at;
    int          drain_mark;
    int          r;
    int          len;
    logic [62:0] long_len;
    logic        msk;
    logic [31:0] key;
    stop_at    = items_sent + RANDOM_ITEMS;
    drain_mark = items_sent;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        gaps_on   = ($urandom_range(0, 2) != 0);
        stalls_on = ($urandom_range(0, 2) != 0);
      end
      r   = $urandom_range(0, 99);
      msk = 1'($urandom_range(0, 1));
      key = $urandom;
      if (r < 70) begin
        len = pick_frame_len();
        send_item(make_start(63'(len), msk, key));
        send_payload(len);
        if ($urandom_range(0, 9) == 0)
          send_item(make_byte(8'($urandom_range(0, 255))));
      end else if (r < 85) begin
        case ($urandom_range(0, 3))
          0, 1: long_len = 63'($urandom_range(8, 40));
          2:    long_len = 63'($urandom_range(126, 65535));
          default: begin
            long_len = random_len63();
          end
        endcase
        send_item(make_start(long_len, msk, key));
        send_payload($urandom_range(0, 5));
      end else if (r < 93) begin
        send_item(make_byte(8'($urandom_range(0, 255))));
      end else begin
        send_item(make_start(random_len63(), msk, key));
      end
      if (items_sent - drain_mark >= DRAIN_EVERY) begin
        wait_drained();
        drain_mark = items_sent;
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_orphan_byte();
    test_empty_frames();
    test_short_masked_frame();
    test_length_codes();
    test_abandoned_frame();
    wait_drained();
    test_random_traffic();

    // All items have transferred: let every owed byte arrive, then watch a
    // little longer for anything extra.
    wait_drained();
    stalls_on = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
src/wstfb_pkg.sv
src/wstfb_front.sv
src/wstfb_queue.sv
src/wstfb_back.sv
src/websocket_text_frame_builder.sv
tb/tb.sv
